// File: design/bes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

    // Default batch size and the element width.
    localparam int unsigned DEF_LENGTH = 8;
    localparam int unsigned DATA_W     = 32;

    // Sequencer states of the sorter.
    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_GET_I,
        S_CMP,
        S_WR_I,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

`default_nettype wire

// File: design/batch_exchange_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_value
// output    out        o_valid / i_stall  o_sorted_value, o_is_last
//
// A request is written into the element store while loading; the last request of a
// batch starts the sort. The sort uses one compare unit and one memory port pair:
// each position i is read into r_a, compared with every later position (swapping
// on the way) and written back; then the results are read out one by one.
// Reset (synchronous, active low) returns to loading an empty batch.
// A stalled output holds the sequencer in its output state; no request is taken
// until all results of the batch have been placed in the output register.

module batch_exchange_sorter
    import bes_pkg::*;
#(
    parameter int unsigned LENGTH = DEF_LENGTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_is_last
);

    localparam int unsigned AW   = $clog2(LENGTH);
    localparam logic [AW-1:0] LAST = AW'(LENGTH - 1);
    localparam logic [AW-1:0] ONE  = AW'(1);

    // Element store and its registered read data.
    logic signed [DATA_W-1:0] mem [LENGTH];
    logic signed [DATA_W-1:0] r_rdata;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_cnt, n_cnt;
    logic [AW-1:0]            r_i, n_i;
    logic [AW-1:0]            r_j, n_j;
    logic [AW-1:0]            r_k, n_k;
    logic signed [DATA_W-1:0] r_a, n_a;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_value, n_out_value;
    logic                     r_out_last, n_out_last;
    logic                     out_load;
    logic                     a_gt;

    // The single compare unit: held element against the element read back.
    assign a_gt = r_a > r_rdata;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Indexes, held element and output payload.
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_a         <= n_a;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // Sequencer: load, exchange sort with position i held in r_a, then emit.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_a         = r_a;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = i_value;
        rd_en       = 1'b0;
        rd_addr     = r_i;
        out_load    = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    mem_we = 1'b1;
                    if (r_cnt == LAST) begin
                        n_cnt   = '0;
                        n_i     = '0;
                        n_state = S_RD_I;
                    end else begin
                        n_cnt = r_cnt + ONE;
                    end
                end
            end
            S_RD_I: begin
                rd_en   = 1'b1;
                n_state = S_GET_I;
            end
            S_GET_I: begin
                n_a     = r_rdata;
                n_j     = r_i + ONE;
                rd_en   = 1'b1;
                rd_addr = r_i + ONE;
                n_state = S_CMP;
            end
            S_CMP: begin
                // Swap when the held earlier element is greater.
                if (a_gt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j;
                    mem_wdata = r_a;
                    n_a       = r_rdata;
                end
                if (r_j == LAST) begin
                    n_state = S_WR_I;
                end else begin
                    n_j     = r_j + ONE;
                    rd_en   = 1'b1;
                    rd_addr = r_j + ONE;
                end
            end
            S_WR_I: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_a;
                if (r_i == LAST - ONE) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i + ONE;
                    rd_en   = 1'b1;
                    rd_addr = r_i + ONE;
                    n_state = S_GET_I;
                end
            end
            S_OUT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k;
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_value = r_rdata;
                    n_out_last  = (r_k == LAST);
                    if (r_k == LAST) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + ONE;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall        = (r_state != S_LOAD);
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_is_last      = r_out_last;

`ifndef SYNTH
    // The load count is only in use while loading.
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_cnt == '0))
        else $error("load count not cleared during sort or output");

    // Every compare is against a later position.
    a_j_after_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j > r_i))
        else $error("compare index not after held position");

    // Results within a batch leave in ascending order.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_k != '0)) |-> (r_rdata >= r_out_value))
        else $error("sorted output out of order");

    // The final result carries the last flag and ends the output phase.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_k == LAST)) |=> (r_state == S_LOAD) && o_is_last)
        else $error("last flag or return to loading missing");
`endif

endmodule

`default_nettype wire

// File: tb/sv/sorted_batch_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sorter. Accepted requests are gathered into a
// batch; when a batch is complete its ascending order is worked out here and
// queued, and every accepted result is compared with the oldest queued entry.
module sorted_batch_checker
    import bes_pkg::*;
#(
    parameter int unsigned LENGTH = DEF_LENGTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_req_valid,
    input  wire logic                     i_req_stall,
    input  wire logic signed [DATA_W-1:0] i_req_value,
    input  wire logic                     i_res_valid,
    input  wire logic                     i_res_stall,
    input  wire logic signed [DATA_W-1:0] i_res_value,
    input  wire logic                     i_res_last,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_results_seen,
    output int                            o_batches_sorted
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_sorted_elem;

    // Values of the batch being loaded, in arrival order.
    logic signed [DATA_W-1:0] batch_buf [LENGTH];
    int unsigned              fill_count;

    // Sorted elements still to come out of the block, oldest first.
    t_sorted_elem             sorted_q [$];
    t_sorted_elem             want;

    int mismatches;
    int results_seen;
    int batches_sorted;

    // Exchange sort of the loaded batch, then queue it smallest first.
    // The buffer is signed, so the comparison is a signed one.
    task automatic queue_sorted_batch();
        logic signed [DATA_W-1:0] swap_tmp;
        t_sorted_elem             elem;
        for (int i = 0; i < LENGTH; i++) begin
            for (int j = i + 1; j < LENGTH; j++) begin
                if (batch_buf[i] > batch_buf[j]) begin
                    swap_tmp     = batch_buf[i];
                    batch_buf[i] = batch_buf[j];
                    batch_buf[j] = swap_tmp;
                end
            end
        end
        for (int k = 0; k < LENGTH; k++) begin
            elem.value = batch_buf[k];
            elem.last  = (k == LENGTH - 1);
            sorted_q.push_back(elem);
        end
    endtask

    initial begin
        fill_count     = 0;
        mismatches     = 0;
        results_seen   = 0;
        batches_sorted = 0;
        o_mismatches     = 0;
        o_outstanding    = 0;
        o_results_seen   = 0;
        o_batches_sorted = 0;
    end

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_count = 0;
        end else begin
            // A request stores one value; the last one of a batch sorts it.
            if (i_req_valid && !i_req_stall) begin
                batch_buf[fill_count] = i_req_value;
                fill_count++;
                if (fill_count == LENGTH) begin
                    queue_sorted_batch();
                    fill_count = 0;
                    batches_sorted++;
                end
            end

            // Compare each accepted result with the oldest expectation.
            if (i_res_valid && !i_res_stall) begin
                results_seen++;
                if (sorted_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("[%0t] unexpected result: value %0d last %0b",
                                 $realtime, i_res_value, i_res_last);
                    end
                    mismatches++;
                end else begin
                    want = sorted_q.pop_front();
                    if (i_res_value !== want.value || i_res_last !== want.last) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("[%0t] result %0d: expected %0d last %0b, got %0d last %0b",
                                     $realtime, results_seen, want.value, want.last,
                                     i_res_value, i_res_last);
                        end
                        mismatches++;
                    end
                end
            end
        end

        o_mismatches     <= mismatches;
        o_outstanding    <= sorted_q.size();
        o_results_seen   <= results_seen;
        o_batches_sorted <= batches_sorted;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Drives batches of signed values into the sorter with bursty requests and a
// stalling receiver; the checker beside the block predicts and compares.
module tb_top;
    import bes_pkg::*;

    localparam int unsigned LENGTH       = DEF_LENGTH;
    localparam int          RAND_BATCHES = 23;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam longint      TIMEOUT_NS   = 2_400_000;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Directed requests: signed extremes mixed with zero, a batch of ties,
    // and a batch in strictly falling order.
    localparam logic signed [DATA_W-1:0] DIRECTED [24] = '{
        VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1, 0,
        -5, -5, -5, -5, -5, -5, -5, -5,
        VAL_MAX, 1000, 7, 0, -7, -1000, VAL_MIN + 1, VAL_MIN
    };

    // Content patterns for the random batches.
    typedef enum int {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_EXTREME,
        SHAPE_ONE_BIT
    } t_batch_shape;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_sorted_value;
    logic                     o_is_last;

    int mismatches;
    int outstanding;
    int results_seen;
    int batches_sorted;

    int burst_left;
    int drain_wait;

    batch_exchange_sorter #(
        .LENGTH(LENGTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_is_last      (o_is_last)
    );

    sorted_batch_checker #(
        .LENGTH(LENGTH)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_req_value      (i_value),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_res_value      (o_sorted_value),
        .i_res_last       (o_is_last),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding),
        .o_results_seen   (results_seen),
        .o_batches_sorted (batches_sorted)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Overall time limit for the run.
    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results still outstanding.", outstanding);
        $display("FAIL batch_exchange_sorter");
        $finish;
    end

    // Offer one request, opening a new burst after a random gap when the
    // current one is used up, and wait until the block takes it.
    task automatic send_request(input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_value <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Send one full batch whose content follows the given pattern.
    task automatic send_batch(input t_batch_shape shape);
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] running;
        int                       pick;
        running = $signed($urandom) >>> 2;
        for (int k = 0; k < LENGTH; k++) begin
            case (shape)
                SHAPE_WIDE: begin
                    value = $urandom;
                end
                SHAPE_NARROW: begin
                    value = $signed($urandom_range(0, 8)) - 4;
                end
                SHAPE_RISING: begin
                    running = running + $signed($urandom_range(0, 1 << 24));
                    value   = running;
                end
                SHAPE_FALLING: begin
                    running = running - $signed($urandom_range(0, 1 << 24));
                    value   = running;
                end
                SHAPE_EXTREME: begin
                    pick = $urandom_range(0, 6);
                    case (pick)
                        0:       value = VAL_MIN;
                        1:       value = VAL_MIN + 1;
                        2:       value = -1;
                        3:       value = 0;
                        4:       value = 1;
                        5:       value = VAL_MAX - 1;
                        default: value = VAL_MAX;
                    endcase
                end
                default: begin
                    value = 32'sd1 << $urandom_range(0, DATA_W - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        value = ~value;
                    end
                end
            endcase
            send_request(value);
        end
    endtask

    // Receiver: stall patterns that change from segment to segment, and one
    // long hold-off once the second batch has started to come out.
    initial begin
        int mode;
        int seg_len;
        bit held_off;
        held_off = 1'b0;
        i_stall <= 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 60);
            repeat (seg_len) begin
                @(posedge i_clk);
                if (!held_off && results_seen >= LENGTH + 1) begin
                    held_off = 1'b1;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       i_stall <= 1'b0;
                        1:       i_stall <= ($urandom_range(0, 3) == 0);
                        2:       i_stall <= ($urandom_range(0, 9) < 6);
                        default: i_stall <= ~i_stall;
                    endcase
                end
            end
        end
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        t_batch_shape shape;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[n]) begin
            send_request(DIRECTED[n]);
        end

        // Random batches; about four in nine use fully random values.
        for (int b = 0; b < RAND_BATCHES; b++) begin
            if ($urandom_range(0, 2) == 0) begin
                shape = SHAPE_WIDE;
            end else begin
                shape = t_batch_shape'($urandom_range(0, 5));
            end
            send_batch(shape);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // Wait for the last results, then let the block settle.
        drain_wait = 0;
        while (outstanding != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (2 * LENGTH + 8) @(posedge i_clk);

        $display("Sorted %0d batches of %0d and checked %0d results; %0d mismatched.",
                 batches_sorted, LENGTH, results_seen, mismatches);
        $display("Covered signed extremes, ties, rising and falling runs, single bits,");
        $display("and a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS batch_exchange_sorter");
        end else begin
            if (outstanding != 0) begin
                $display("%0d expected results never arrived.", outstanding);
            end
            $display("FAIL batch_exchange_sorter");
        end
        $finish;
    end

endmodule

// File: sim.f
design/bes_pkg.sv
design/batch_exchange_sorter.sv
tb/sv/sorted_batch_checker.sv
tb/sv/tb_top.sv
